// ===== design/csem_pkg.sv =====
// Package for the counting semaphore table: operation and status codes,
// default sizes and the command and result structs. It depends on nothing.
package csem_pkg;

  localparam int SLOTS_DEFAULT   = 16;
  localparam int WAITERS_DEFAULT = 8;
  localparam int THREADS_DEFAULT = 32;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOCK   = 2'd2;
  localparam logic [1:0] OP_UNLOCK = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;
  localparam logic [1:0] STATUS_QUEUE_FULL = 2'd3;

  localparam logic signed [15:0] COUNT_TOP = 16'sd32767;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] sem_number;
    logic [14:0] initial_count;
    logic [4:0]  caller_thread;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        created_number;
    logic               must_wait;
    logic               wake_valid;
    logic [4:0]         wake_thread;
    logic signed [15:0] count_after;
  } res_t;

endpackage

// ===== design/csem_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
// Used for the slot records and for the waiter queues; no package needed.
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/counting_semaphore_table.sv =====
// Top level of the counting semaphore table: sequencer, slot scan and queue update.
// Depends on csem_pkg and on csem_ram for the slot records and the waiter queues.
//
//   channel   ports              transfer when
//   command   start, busy, cmd   start high and busy low at a rising edge
//   result    done, result       done high, for exactly one cycle
//
// One shared comparator steps through the slots, one slot per cycle.
// Create takes the lowest free slot, or reports a full table after the last slot.
// Remove, lock and unlock scan for the slot that holds the identifier, then execute;
// an unlock that wakes a waiter adds a wake state; a miss reports after the last slot.
// After reset no slot is in use; memories need no clearing pass.
// The receiver cannot stall; busy is low again in the cycle the result shows.
module counting_semaphore_table
  import csem_pkg::*;
#(
  parameter int SLOTS   = SLOTS_DEFAULT,
  parameter int WAITERS = WAITERS_DEFAULT,
  parameter int THREADS = THREADS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  localparam int SIDX  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW    = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int LW    = $clog2(WAITERS + 1);
  localparam int PW    = LW + 1;
  localparam int REC_W = 32 + HW + LW;
  localparam int WAW   = SIDX + HW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FREE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_EXEC = 3'd3;
  localparam logic [2:0] ST_WAKE = 3'd4;

  localparam logic [SIDX-1:0] LAST_SLOT = SIDX'(SLOTS - 1);

  logic [2:0]         state;
  logic [SIDX-1:0]    scan_idx;
  logic [SIDX-1:0]    rd_idx;
  logic               rd_pend;
  logic [SIDX-1:0]    slot;
  logic [SLOTS-1:0]   used;
  logic [15:0]        next_ident;
  logic [1:0]         op;
  logic [15:0]        ident;
  logic [14:0]        init;
  logic [4:0]         thread;
  logic signed [15:0] rec_count;
  logic [HW-1:0]      rec_head;
  logic [LW-1:0]      rec_len;

  logic [4:0]         tmod_tab [32];

  logic               slot_we;
  logic [SIDX-1:0]    slot_waddr;
  logic [REC_W-1:0]   slot_wdata;
  logic [REC_W-1:0]   slot_rdata;
  logic [15:0]        rd_ident;
  logic               rd_match;

  logic               wait_we;
  logic [WAW-1:0]     wait_waddr;
  logic [4:0]         wait_rdata;

  logic signed [15:0] cnt_dec;
  logic signed [15:0] cnt_inc;
  logic [PW-1:0]      tail_sum;
  logic [HW-1:0]      tail;
  logic [PW-1:0]      head_sum;
  logic [HW-1:0]      head_next;
  logic               queue_full;
  logic               wake;

  for (genvar i = 0; i < 32; i++) begin : g_tmod
    localparam logic [4:0] TMOD = 5'(i % THREADS);
    assign tmod_tab[i] = TMOD;
  end

  csem_ram #(
    .WIDTH(REC_W),
    .DEPTH(SLOTS),
    .AW   (SIDX)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .raddr(scan_idx),
    .rdata(slot_rdata)
  );

  csem_ram #(
    .WIDTH(5),
    .DEPTH(SLOTS << HW),
    .AW   (WAW)
  ) u_wait_ram (
    .clk  (clk),
    .we   (wait_we),
    .waddr(wait_waddr),
    .wdata(thread),
    .raddr({slot, rec_head}),
    .rdata(wait_rdata)
  );

  assign busy     = (state != ST_IDLE);
  assign rd_ident = slot_rdata[REC_W-1 -: 16];
  assign rd_match = rd_pend && used[rd_idx] && (rd_ident == ident);

  always_comb begin
    cnt_dec    = rec_count - 16'sd1;
    cnt_inc    = (rec_count < COUNT_TOP) ? rec_count + 16'sd1 : rec_count;
    tail_sum   = PW'(rec_head) + PW'(rec_len);
    tail       = (tail_sum >= PW'(WAITERS)) ? HW'(tail_sum - PW'(WAITERS)) : HW'(tail_sum);
    head_sum   = PW'(rec_head) + PW'(1);
    head_next  = (head_sum == PW'(WAITERS)) ? '0 : HW'(head_sum);
    queue_full = (rec_len >= LW'(WAITERS));
    wake       = (cnt_inc <= 16'sd0) && (rec_len != '0);
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot;
    slot_wdata = {ident, rec_count, rec_head, rec_len};
    wait_we    = 1'b0;
    wait_waddr = {slot, tail};
    case (state)
      ST_FREE: begin
        slot_waddr = scan_idx;
        slot_wdata = {next_ident, {1'b0, init}, {HW{1'b0}}, {LW{1'b0}}};
        slot_we    = !used[scan_idx];
      end
      ST_EXEC: begin
        if (op == OP_LOCK) begin
          if (cnt_dec >= 16'sd0) begin
            slot_we    = 1'b1;
            slot_wdata = {ident, cnt_dec, rec_head, rec_len};
          end else if (!queue_full) begin
            slot_we    = 1'b1;
            wait_we    = 1'b1;
            slot_wdata = {ident, cnt_dec, rec_head, rec_len + LW'(1)};
          end
        end else if (op == OP_UNLOCK) begin
          slot_we = 1'b1;
          if (wake) begin
            slot_wdata = {ident, cnt_inc, head_next, rec_len - LW'(1)};
          end else begin
            slot_wdata = {ident, cnt_inc, rec_head, rec_len};
          end
        end
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      next_ident <= '0;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            op       <= cmd.opcode;
            ident    <= cmd.sem_number;
            init     <= cmd.initial_count;
            thread   <= tmod_tab[cmd.caller_thread];
            scan_idx <= '0;
            rd_pend  <= 1'b0;
            state    <= (cmd.opcode == OP_CREATE) ? ST_FREE : ST_SCAN;
          end
        end
        ST_FREE: begin
          if (!used[scan_idx]) begin
            used[scan_idx] <= 1'b1;
            next_ident     <= next_ident + 16'd1;
            result         <= '{STATUS_OK, next_ident, 1'b0, 1'b0, 5'd0,
                                16'(signed'({1'b0, init}))};
            done           <= 1'b1;
            state          <= ST_IDLE;
          end else if (scan_idx == LAST_SLOT) begin
            result <= '{STATUS_TABLE_FULL, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0};
            done   <= 1'b1;
            state  <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + SIDX'(1);
          end
        end
        ST_SCAN: begin
          rd_idx  <= scan_idx;
          rd_pend <= 1'b1;
          if (rd_match) begin
            slot      <= rd_idx;
            rec_count <= signed'(slot_rdata[REC_W-17 -: 16]);
            rec_head  <= slot_rdata[LW +: HW];
            rec_len   <= slot_rdata[LW-1:0];
            state     <= ST_EXEC;
          end else if (rd_pend && (rd_idx == LAST_SLOT)) begin
            result <= '{STATUS_NOT_FOUND, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0};
            done   <= 1'b1;
            state  <= ST_IDLE;
          end else if (scan_idx != LAST_SLOT) begin
            scan_idx <= scan_idx + SIDX'(1);
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          case (op)
            OP_REMOVE: begin
              used[slot] <= 1'b0;
              result     <= '{STATUS_OK, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0};
            end
            OP_LOCK: begin
              if (cnt_dec >= 16'sd0) begin
                result <= '{STATUS_OK, 16'd0, 1'b0, 1'b0, 5'd0, cnt_dec};
              end else if (queue_full) begin
                result <= '{STATUS_QUEUE_FULL, 16'd0, 1'b0, 1'b0, 5'd0, rec_count};
              end else begin
                result <= '{STATUS_OK, 16'd0, 1'b1, 1'b0, 5'd0, cnt_dec};
              end
            end
            OP_UNLOCK: begin
              result <= '{STATUS_OK, 16'd0, 1'b0, wake, 5'd0, cnt_inc};
              if (wake) begin
                done  <= 1'b0;
                state <= ST_WAKE;
              end
            end
            default: begin
              result <= '{STATUS_NOT_FOUND, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0};
            end
          endcase
        end
        ST_WAKE: begin
          result.wake_thread <= wait_rdata;
          done               <= 1'b1;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while an operation is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not make the block busy");

  a_wait_wake: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.must_wait && result.wake_valid))
    else $error("one result both blocks and wakes a thread");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_OK) |-> (result.created_number == 16'd0
      && !result.must_wait && !result.wake_valid))
    else $error("failed operation reports a side effect");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for counting_semaphore_table: directed table and random commands, each result
// checked against its table row or a behavioural model of the table. Depends on csem_pkg and the RTL.
module testbench;
  import csem_pkg::*;

  localparam int SLOTS        = SLOTS_DEFAULT;
  localparam int WAITERS      = WAITERS_DEFAULT;
  localparam int THREADS      = THREADS_DEFAULT;
  localparam int RANDOM_ITEMS = 900;
  localparam longint LIMIT_CYCLES = 8_000_000;

  typedef struct {
    cmd_t c;
    int   reps;
    bit   known;
    res_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  res_t result;

  logic               sem_used  [SLOTS];
  logic [15:0]        sem_ident [SLOTS];
  logic signed [15:0] sem_count [SLOTS];
  int                 wait_head [SLOTS];
  int                 wait_len  [SLOTS];
  logic [4:0]         wait_ring [SLOTS][WAITERS];
  logic [15:0]        model_next_id;

  res_t      expected_results[$];
  plan_row_t directed_plan[$];
  int        mismatches = 0;
  longint    cycle_count = 0;
  int        op_seen[4];
  int        status_seen[4];
  int        blocked_locks;
  int        wake_ups;
  bit        burst;

  counting_semaphore_table u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int find_sem(input logic [15:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (sem_used[i] && sem_ident[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic res_t semaphore_step(input cmd_t c);
    res_t               r;
    int                 s;
    logic signed [15:0] n;
    r = '0;
    if (c.opcode == OP_CREATE) begin
      s = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!sem_used[i]) s = i;
      end
      if (s < 0) begin
        r.status = STATUS_TABLE_FULL;
        return r;
      end
      sem_used[s]      = 1'b1;
      sem_ident[s]     = model_next_id;
      sem_count[s]     = {1'b0, c.initial_count};
      wait_head[s]     = 0;
      wait_len[s]      = 0;
      r.created_number = model_next_id;
      r.count_after    = sem_count[s];
      model_next_id    = model_next_id + 16'd1;
      return r;
    end
    s = find_sem(c.sem_number);
    if (s < 0) begin
      r.status = STATUS_NOT_FOUND;
      return r;
    end
    case (c.opcode)
      OP_REMOVE: begin
        sem_used[s] = 1'b0;
        wait_len[s] = 0;
      end
      OP_LOCK: begin
        n = sem_count[s] - 16'sd1;
        if (n < 0) begin
          if (wait_len[s] >= WAITERS) begin
            r.status      = STATUS_QUEUE_FULL;
            r.count_after = sem_count[s];
          end else begin
            wait_ring[s][(wait_head[s] + wait_len[s]) % WAITERS] =
              5'(c.caller_thread % THREADS);
            wait_len[s]   = wait_len[s] + 1;
            sem_count[s]  = n;
            r.must_wait   = 1'b1;
            r.count_after = n;
          end
        end else begin
          sem_count[s]  = n;
          r.count_after = n;
        end
      end
      default: begin
        if (sem_count[s] < COUNT_TOP) sem_count[s] = sem_count[s] + 16'sd1;
        if (sem_count[s] <= 0 && wait_len[s] > 0) begin
          r.wake_valid  = 1'b1;
          r.wake_thread = wait_ring[s][wait_head[s] % WAITERS];
          wait_head[s]  = (wait_head[s] + 1) % WAITERS;
          wait_len[s]   = wait_len[s] - 1;
        end
        r.count_after = sem_count[s];
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t op_cmd(input logic [1:0] op, input logic [15:0] num,
                                  input logic [14:0] cnt, input logic [4:0] thr);
    cmd_t c;
    c.opcode        = op;
    c.sem_number    = num;
    c.initial_count = cnt;
    c.caller_thread = thr;
    return c;
  endfunction

  function automatic res_t reply(input logic [1:0] st, input logic [15:0] made,
                                 input logic blocked, input logic woke,
                                 input logic [4:0] thr, input logic signed [15:0] cnt);
    res_t r;
    r.status         = st;
    r.created_number = made;
    r.must_wait      = blocked;
    r.wake_valid     = woke;
    r.wake_thread    = thr;
    r.count_after    = cnt;
    return r;
  endfunction

  task automatic add_row(input cmd_t c, input int reps, input bit known, input res_t want);
    plan_row_t row;
    row.c     = c;
    row.reps  = reps;
    row.known = known;
    row.want  = want;
    directed_plan.push_back(row);
  endtask

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one command and waits for its transfer; the model advances at that edge.
  task automatic issue(input cmd_t c, input int gap, input bit known, input res_t want);
    res_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    predicted = semaphore_step(c);
    expected_results.push_back(known ? want : predicted);
    op_seen[c.opcode]++;
    status_seen[predicted.status]++;
    if (predicted.must_wait) blocked_locks++;
    if (predicted.wake_valid) wake_ups++;
  endtask

  function automatic cmd_t random_command();
    cmd_t c;
    int   r;
    int   live;
    int   pick;
    c.sem_number    = 16'($urandom);
    c.initial_count = 15'($urandom);
    c.caller_thread = 5'($urandom);
    live = 0;
    for (int i = 0; i < SLOTS; i++) live += sem_used[i];
    r = $urandom_range(0, 99);
    if (live == 0 || r < (live < 4 ? 40 : 15)) begin
      c.opcode = OP_CREATE;
      r = $urandom_range(0, 99);
      if (r < 60) c.initial_count = 15'($urandom_range(0, 3));
      else if (r < 85) c.initial_count = 15'h7FFF - 15'($urandom_range(0, 1));
    end else begin
      if (r < 27) c.opcode = OP_REMOVE;
      else if (r < 63) c.opcode = OP_LOCK;
      else c.opcode = OP_UNLOCK;
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, live - 1);
        for (int i = 0; i < SLOTS; i++) begin
          if (sem_used[i]) begin
            if (pick == 0) c.sem_number = sem_ident[i];
            pick--;
          end
        end
      end
    end
    return c;
  endfunction

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want !== got) begin
      $display("%0t: %s differs, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, result);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, result.status);
        compare_field("created_number", want.created_number, result.created_number);
        compare_field("must_wait", want.must_wait, result.must_wait);
        compare_field("wake_valid", want.wake_valid, result.wake_valid);
        compare_field("wake_thread", want.wake_thread, result.wake_thread);
        compare_field("count_after", $signed(want.count_after), $signed(result.count_after));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    cmd_t c;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    blocked_locks = 0;
    wake_ups      = 0;
    burst         = 1'b0;
    model_next_id = '0;
    for (int i = 0; i < 4; i++) begin
      op_seen[i]     = 0;
      status_seen[i] = 0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      sem_used[i]  = 1'b0;
      sem_ident[i] = '0;
      sem_count[i] = '0;
      wait_head[i] = 0;
      wait_len[i]  = 0;
      for (int j = 0; j < WAITERS; j++) wait_ring[i][j] = '0;
    end

    add_row(op_cmd(OP_REMOVE, 16'h0000, 15'h7FFF, 5'd31), 1, 1,
            reply(STATUS_NOT_FOUND, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_LOCK, 16'h0000, 15'd0, 5'd5), 1, 1,
            reply(STATUS_NOT_FOUND, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_UNLOCK, 16'hFFFF, 15'd0, 5'd0), 1, 1,
            reply(STATUS_NOT_FOUND, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_CREATE, 16'hFFFF, 15'd0, 5'd31), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_CREATE, 16'h0000, 15'h7FFF, 5'd0), 1, 1,
            reply(STATUS_OK, 16'd1, 1'b0, 1'b0, 5'd0, 16'sd32767));
    add_row(op_cmd(OP_UNLOCK, 16'h0001, 15'h7FFF, 5'd31), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd32767));
    add_row(op_cmd(OP_LOCK, 16'h0001, 15'h7FFF, 5'd3), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd32766));
    add_row(op_cmd(OP_LOCK, 16'h0000, 15'd0, 5'd31), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b1, 1'b0, 5'd0, -16'sd1));
    add_row(op_cmd(OP_LOCK, 16'h0000, 15'h7FFF, 5'd0), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b1, 1'b0, 5'd0, -16'sd2));
    add_row(op_cmd(OP_LOCK, 16'h0000, 15'd0, 5'd10), 6, 0, '0);
    add_row(op_cmd(OP_LOCK, 16'h0000, 15'd0, 5'd9), 1, 1,
            reply(STATUS_QUEUE_FULL, 16'd0, 1'b0, 1'b0, 5'd0, -16'sd8));
    add_row(op_cmd(OP_UNLOCK, 16'h0000, 15'd0, 5'd0), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b0, 1'b1, 5'd31, -16'sd7));
    add_row(op_cmd(OP_UNLOCK, 16'h0000, 15'd0, 5'd0), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b0, 1'b1, 5'd0, -16'sd6));
    add_row(op_cmd(OP_LOCK, 16'h0000, 15'd0, 5'd20), 2, 0, '0);
    add_row(op_cmd(OP_UNLOCK, 16'h0000, 15'd0, 5'd0), 7, 0, '0);
    add_row(op_cmd(OP_REMOVE, 16'h0000, 15'd0, 5'd0), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_LOCK, 16'h0000, 15'd0, 5'd0), 1, 1,
            reply(STATUS_NOT_FOUND, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_CREATE, 16'h5A5A, 15'd1, 5'd7), 15, 0, '0);
    add_row(op_cmd(OP_CREATE, 16'h0000, 15'd4, 5'd0), 1, 1,
            reply(STATUS_TABLE_FULL, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_REMOVE, 16'h0001, 15'd0, 5'd0), 1, 1,
            reply(STATUS_OK, 16'd0, 1'b0, 1'b0, 5'd0, 16'sd0));
    add_row(op_cmd(OP_CREATE, 16'hFFFF, 15'd5, 5'd31), 1, 1,
            reply(STATUS_OK, 16'd17, 1'b0, 1'b0, 5'd0, 16'sd5));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      for (int k = 0; k < directed_plan[r].reps; k++) begin
        c = directed_plan[r].c;
        c.caller_thread = c.caller_thread + 5'(k);
        c.initial_count = c.initial_count + 15'(k);
        issue(c, pick_gap(), directed_plan[r].known, directed_plan[r].want);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      issue(random_command(), pick_gap(), 0, '0);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("Run covered %0d transfers: %0d create, %0d remove, %0d lock, %0d unlock.",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[OP_CREATE], op_seen[OP_REMOVE], op_seen[OP_LOCK], op_seen[OP_UNLOCK]);
    $display("Outcomes: %0d not found, %0d table full, %0d queue full, %0d blocked, %0d woken.",
             status_seen[STATUS_NOT_FOUND], status_seen[STATUS_TABLE_FULL],
             status_seen[STATUS_QUEUE_FULL], blocked_locks, wake_ups);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/csem_pkg.sv
design/csem_ram.sv
design/counting_semaphore_table.sv
bench/testbench.sv
